@@ rtl/mi3_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;

    localparam int ELEM_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int DET_W          = 49;
    localparam int N_ELEM         = 9;

    // Element indexes (row-major) of each adjugate minor: p*q - r*s
    localparam int MIN_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

endpackage
`default_nettype wire

@@ rtl/matrix3_inverse_determinant.sv @@
`timescale 1ns / 1ps
`default_nettype none
// 3x3 matrix inverse and determinant by adjugate, fully pipelined.
// Stages: minor products, adjugate, determinant terms, sum, magnitude, divider, output.
// One matrix per cycle unless stalled; the nine quotient dividers take one bit per stage.
// Reset (synchronous, active low) clears the valid bits of every stage; data is not reset.
// A stall at the output freezes the whole pipeline, and input ready follows it.
module matrix3_inverse_determinant
    import mi3_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire signed [ELEM_WIDTH-1:0] i_a_r0c0,
    input  wire signed [ELEM_WIDTH-1:0] i_a_r0c1,
    input  wire signed [ELEM_WIDTH-1:0] i_a_r0c2,
    input  wire signed [ELEM_WIDTH-1:0] i_a_r1c0,
    input  wire signed [ELEM_WIDTH-1:0] i_a_r1c1,
    input  wire signed [ELEM_WIDTH-1:0] i_a_r1c2,
    input  wire signed [ELEM_WIDTH-1:0] i_a_r2c0,
    input  wire signed [ELEM_WIDTH-1:0] i_a_r2c1,
    input  wire signed [ELEM_WIDTH-1:0] i_a_r2c2,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic signed [ELEM_WIDTH-1:0] o_inv_r0c0,
    output logic signed [ELEM_WIDTH-1:0] o_inv_r0c1,
    output logic signed [ELEM_WIDTH-1:0] o_inv_r0c2,
    output logic signed [ELEM_WIDTH-1:0] o_inv_r1c0,
    output logic signed [ELEM_WIDTH-1:0] o_inv_r1c1,
    output logic signed [ELEM_WIDTH-1:0] o_inv_r1c2,
    output logic signed [ELEM_WIDTH-1:0] o_inv_r2c0,
    output logic signed [ELEM_WIDTH-1:0] o_inv_r2c1,
    output logic signed [ELEM_WIDTH-1:0] o_inv_r2c2,
    output logic signed [DET_W-1:0]     o_det_value,
    output logic                        o_singular
);

    localparam int EW = ELEM_WIDTH;
    localparam int PW = 2 * EW;
    localparam int MW = 2 * EW + 1;
    localparam int TW = EW + MW;
    localparam int DW = 3 * EW + 3;
    localparam int QW = EW + 1;
    localparam int D  = QW;
    localparam int NW = MW + 2 * FRAC_BITS;
    localparam int UW = (DW + QW + 1 > NW) ? DW + QW + 1 : NW + 1;
    localparam int XW = (DW > DET_W) ? DW : DET_W;
    localparam logic [QW-1:0] HIQ = {2'b00, {(EW-1){1'b1}}};
    localparam logic [QW-1:0] LOQ = {2'b01, {(EW-1){1'b0}}};

    logic en;
    logic signed [EW-1:0] m [N_ELEM];

    // stage 1: minor products
    logic                 r1_vld;
    logic signed [PW-1:0] r1_p [N_ELEM][2];
    logic signed [EW-1:0] r1_abc [3];
    // stage 2: adjugate
    logic                 r2_vld;
    logic signed [MW-1:0] r2_adj [N_ELEM];
    logic signed [EW-1:0] r2_abc [3];
    // stage 3: determinant terms, numerator magnitudes
    logic                 r3_vld;
    logic signed [TW-1:0] r3_dp [3];
    logic [UW-1:0]        r3_nab [N_ELEM];
    logic                 r3_nng [N_ELEM];
    // stage 4: determinant sum
    logic                 r4_vld;
    logic signed [DW-1:0] r4_det;
    logic [UW-1:0]        r4_nab [N_ELEM];
    logic                 r4_nng [N_ELEM];
    // stage 5: determinant magnitude
    logic                 r5_vld;
    logic signed [DW-1:0] r5_det;
    logic [UW-1:0]        r5_dab;
    logic                 r5_dz;
    logic [UW-1:0]        r5_nab [N_ELEM];
    logic                 r5_sg [N_ELEM];
    // divider stages
    logic                 r_vld [0:D];
    logic signed [DW-1:0] r_det [0:D];
    logic [UW-1:0]        r_dab [0:D];
    logic                 r_dz  [0:D];
    logic [UW-1:0]        r_rem [0:D][N_ELEM];
    logic [QW-1:0]        r_q   [0:D][N_ELEM];
    logic                 r_ov  [0:D][N_ELEM];
    logic                 r_sg  [0:D][N_ELEM];
    // output stage
    logic                 r_out_vld;
    logic signed [EW-1:0] r_inv [N_ELEM];
    logic signed [DET_W-1:0] r_det_out;
    logic                 r_sing;

    // advance all stages together whenever the output register can take data
    assign en = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    assign m[0] = i_a_r0c0;
    assign m[1] = i_a_r0c1;
    assign m[2] = i_a_r0c2;
    assign m[3] = i_a_r1c0;
    assign m[4] = i_a_r1c1;
    assign m[5] = i_a_r1c2;
    assign m[6] = i_a_r2c0;
    assign m[7] = i_a_r2c1;
    assign m[8] = i_a_r2c2;

    // valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    // front stages: minors, determinant, magnitudes
    always_ff @(posedge i_clk) begin
        logic [MW-1:0] t_abs;
        logic [DW-1:0] t_dab;
        if (en) begin
            for (int k = 0; k < N_ELEM; k++) begin
                r1_p[k][0] <= m[MIN_IDX[k][0]] * m[MIN_IDX[k][1]];
                r1_p[k][1] <= m[MIN_IDX[k][2]] * m[MIN_IDX[k][3]];
            end
            for (int j = 0; j < 3; j++) begin
                r1_abc[j] <= m[j];
                r2_abc[j] <= r1_abc[j];
            end
            for (int k = 0; k < N_ELEM; k++) begin
                r2_adj[k] <= MW'(r1_p[k][0]) - MW'(r1_p[k][1]);
            end
            r3_dp[0] <= r2_abc[0] * r2_adj[0];
            r3_dp[1] <= r2_abc[1] * r2_adj[3];
            r3_dp[2] <= r2_abc[2] * r2_adj[6];
            for (int k = 0; k < N_ELEM; k++) begin
                t_abs = r2_adj[k][MW-1] ? (~r2_adj[k] + MW'(1)) : r2_adj[k];
                r3_nab[k] <= UW'(t_abs) << (2 * FRAC_BITS);
                r3_nng[k] <= r2_adj[k][MW-1];
            end
            r4_det <= DW'(r3_dp[0]) + DW'(r3_dp[1]) + DW'(r3_dp[2]);
            for (int k = 0; k < N_ELEM; k++) begin
                r4_nab[k] <= r3_nab[k];
                r4_nng[k] <= r3_nng[k];
            end
            t_dab = r4_det[DW-1] ? (~r4_det + DW'(1)) : r4_det;
            r5_det <= r4_det;
            r5_dab <= UW'(t_dab);
            r5_dz  <= (r4_det == '0);
            for (int k = 0; k < N_ELEM; k++) begin
                r5_nab[k] <= r4_nab[k];
                r5_sg[k]  <= r4_nng[k] ^ r4_det[DW-1];
            end
        end
    end

    // divider entry: flag quotients that exceed the bits computed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det[0] <= r5_det;
            r_dab[0] <= r5_dab;
            r_dz[0]  <= r5_dz;
            for (int k = 0; k < N_ELEM; k++) begin
                r_rem[0][k] <= r5_nab[k];
                r_q[0][k]   <= '0;
                r_ov[0][k]  <= (r5_nab[k] >= (r5_dab << QW));
                r_sg[0][k]  <= r5_sg[k];
            end
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar s = 1; s <= D; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            logic [UW-1:0] t_sub;
            logic          t_bit;
            if (en) begin
                t_sub = r_dab[s-1] << (D - s);
                r_det[s] <= r_det[s-1];
                r_dab[s] <= r_dab[s-1];
                r_dz[s]  <= r_dz[s-1];
                for (int k = 0; k < N_ELEM; k++) begin
                    t_bit = (r_rem[s-1][k] >= t_sub);
                    r_rem[s][k] <= t_bit ? (r_rem[s-1][k] - t_sub) : r_rem[s-1][k];
                    r_q[s][k]   <= {r_q[s-1][k][QW-2:0], t_bit};
                    r_ov[s][k]  <= r_ov[s-1][k];
                    r_sg[s][k]  <= r_sg[s-1][k];
                end
            end
        end
    end

    // output stage: apply sign, saturate, zero a singular result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[D];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [QW-1:0]        t_mag;
        logic signed [XW-1:0] t_dx;
        if (en) begin
            t_dx = XW'(r_det[D]);
            for (int k = 0; k < N_ELEM; k++) begin
                t_mag = r_q[D][k];
                if (r_dz[D]) begin
                    r_inv[k] <= '0;
                end else if (!r_sg[D][k]) begin
                    r_inv[k] <= (r_ov[D][k] || t_mag > HIQ) ? EW'(HIQ) : EW'(t_mag);
                end else begin
                    r_inv[k] <= (r_ov[D][k] || t_mag > LOQ) ? EW'(LOQ) : -EW'(t_mag);
                end
            end
            r_det_out <= r_dz[D] ? '0 : t_dx[DET_W-1:0];
            r_sing    <= r_dz[D];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_inv_r0c0  = r_inv[0];
    assign o_inv_r0c1  = r_inv[1];
    assign o_inv_r0c2  = r_inv[2];
    assign o_inv_r1c0  = r_inv[3];
    assign o_inv_r1c1  = r_inv[4];
    assign o_inv_r1c2  = r_inv[5];
    assign o_inv_r2c0  = r_inv[6];
    assign o_inv_r2c1  = r_inv[7];
    assign o_inv_r2c2  = r_inv[8];
    assign o_det_value = r_det_out;
    assign o_singular  = r_sing;

endmodule
`default_nettype wire

@@ verif/matrix3_inverse_checker.sv @@
`timescale 1ns / 1ps
module matrix3_inverse_checker
    import mi3_pkg::*;
(
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire                          i_in_ready,
    input  wire [N_ELEM-1:0][15:0]       i_elems,
    input  wire                          i_out_valid,
    input  wire                          i_out_ready,
    input  wire [N_ELEM-1:0][15:0]       i_inv,
    input  wire [DET_W-1:0]              i_det,
    input  wire                          i_singular,
    output int                           o_fail_count,
    output int                           o_pending
);

    typedef struct {
        logic [15:0]      inv [N_ELEM];
        logic [DET_W-1:0] det;
        logic             singular;
    } t_inverse;

    t_inverse pending_inverses[$];

    // Exact adjugate inverse; all intermediates fit in 64 bits at 16-bit elements
    function automatic t_inverse invert_matrix(input logic [N_ELEM-1:0][15:0] m);
        longint   el [N_ELEM];
        longint   adj [N_ELEM];
        longint   det;
        longint   quo;
        t_inverse r;
        for (int k = 0; k < N_ELEM; k++) el[k] = longint'($signed(m[k]));
        adj[0] = el[4] * el[8] - el[5] * el[7];
        adj[1] = el[2] * el[7] - el[1] * el[8];
        adj[2] = el[1] * el[5] - el[2] * el[4];
        adj[3] = el[5] * el[6] - el[3] * el[8];
        adj[4] = el[0] * el[8] - el[2] * el[6];
        adj[5] = el[2] * el[3] - el[0] * el[5];
        adj[6] = el[3] * el[7] - el[4] * el[6];
        adj[7] = el[1] * el[6] - el[0] * el[7];
        adj[8] = el[0] * el[4] - el[1] * el[3];
        det = el[0] * adj[0] + el[1] * adj[3] + el[2] * adj[6];
        r.singular = (det == 0);
        r.det = r.singular ? '0 : det[DET_W-1:0];
        for (int k = 0; k < N_ELEM; k++) begin
            if (r.singular) begin
                r.inv[k] = '0;
            end else begin
                quo = (adj[k] <<< 16) / det;
                if (quo > 32767) quo = 32767;
                if (quo < -32768) quo = -32768;
                r.inv[k] = quo[15:0];
            end
        end
        return r;
    endfunction

    function automatic void report(input string what, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        if (o_fail_count < 10)
            $display("%0t %s: expected %h, got %h", $realtime, what, exp_v, got_v);
        o_fail_count++;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    // Predict on each input transfer, compare on each output transfer
    always @(posedge i_clk) begin
        t_inverse want;
        if (i_rst_n && i_in_valid && i_in_ready)
            pending_inverses.push_back(invert_matrix(i_elems));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (pending_inverses.size() == 0) begin
                report("unexpected result", 64'(0), {15'b0, i_det});
            end else begin
                want = pending_inverses.pop_front();
                for (int k = 0; k < N_ELEM; k++)
                    if (i_inv[k] !== want.inv[k])
                        report($sformatf("inv element %0d", k), 64'(want.inv[k]),
                               64'(i_inv[k]));
                if (i_det !== want.det) report("det_value", 64'(want.det), 64'(i_det));
                if (i_singular !== want.singular)
                    report("singular", 64'(want.singular), 64'(i_singular));
            end
        end
        o_pending = pending_inverses.size();
    end

endmodule

@@ verif/tb_matrix3_inverse_determinant.sv @@
`timescale 1ns / 1ps
module tb_matrix3_inverse_determinant;
    import mi3_pkg::*;

    localparam int NUM_RANDOM  = 1230;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic in_ready, out_valid, singular;
    logic [N_ELEM-1:0][15:0] elems = '0;
    logic [N_ELEM-1:0][15:0] inv;
    logic [DET_W-1:0] det;
    int fail_count, pending, cycle_count = 0;

    always #4 i_clk = ~i_clk;

    matrix3_inverse_determinant i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_a_r0c0(elems[0]), .i_a_r0c1(elems[1]), .i_a_r0c2(elems[2]),
        .i_a_r1c0(elems[3]), .i_a_r1c1(elems[4]), .i_a_r1c2(elems[5]),
        .i_a_r2c0(elems[6]), .i_a_r2c1(elems[7]), .i_a_r2c2(elems[8]),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_inv_r0c0(inv[0]), .o_inv_r0c1(inv[1]), .o_inv_r0c2(inv[2]),
        .o_inv_r1c0(inv[3]), .o_inv_r1c1(inv[4]), .o_inv_r1c2(inv[5]),
        .o_inv_r2c0(inv[6]), .o_inv_r2c1(inv[7]), .o_inv_r2c2(inv[8]),
        .o_det_value(det), .o_singular(singular)
    );

    matrix3_inverse_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_elems(elems),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_inv(inv), .i_det(det), .i_singular(singular),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Present one matrix, idling first at random, and hold it until transfer
    task automatic send_matrix(input logic [N_ELEM-1:0][15:0] m, input bit may_idle);
        while (may_idle && $urandom_range(99) < 6) begin
            @(negedge i_clk);
            in_valid = 1'b0;
        end
        @(negedge i_clk);
        in_valid = 1'b1;
        elems = m;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    function automatic logic [N_ELEM-1:0][15:0] diag(input logic [15:0] v);
        logic [N_ELEM-1:0][15:0] m = '0;
        m[0] = v;
        m[4] = v;
        m[8] = v;
        return m;
    endfunction

    // Random matrix: full range, near-unit Q8.8 values (some made singular), or tiny values
    function automatic logic [N_ELEM-1:0][15:0] random_matrix();
        logic [N_ELEM-1:0][15:0] m;
        int kind = $urandom_range(9);
        for (int k = 0; k < N_ELEM; k++) begin
            if (kind < 4) m[k] = 16'($urandom);
            else if (kind < 8) m[k] = 16'($signed($urandom_range(1024)) - 512);
            else m[k] = 16'($signed($urandom_range(16)) - 8);
        end
        if (kind == 7) begin
            m[6] = m[0];
            m[7] = m[1];
            m[8] = m[2];
        end
        return m;
    endfunction

    // Receiver: random stalls, one long hold-off, and a stall-free stretch
    initial begin
        int rx_cycle;
        rx_cycle = 0;
        @(negedge i_clk);
        forever begin
            if (rx_cycle >= 600 && rx_cycle < 800) out_ready = 1'b0;
            else if (rx_cycle >= 1000 && rx_cycle < 1300) out_ready = 1'b1;
            else out_ready = ($urandom_range(99) >= 6);
            rx_cycle++;
            @(negedge i_clk);
        end
    end

    // Abort on a hung pipeline
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("matrix3_inverse_determinant: mismatch");
            $finish;
        end
    end

    initial begin
        logic [N_ELEM-1:0][15:0] m;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zero, identity, extremes, saturation, negative determinant
        send_matrix('0, 0);
        send_matrix(diag(16'h0100), 0);
        send_matrix(diag(16'h7fff), 0);
        send_matrix(diag(16'h8000), 0);
        send_matrix(diag(16'h0001), 0);
        send_matrix(diag(16'hffff), 0);
        send_matrix({N_ELEM{16'h7fff}}, 0);
        send_matrix({N_ELEM{16'h8000}}, 0);
        m = diag(16'h0100);
        m[0] = 16'hff00;
        send_matrix(m, 0);
        m = diag(16'h8000);
        m[1] = 16'h7fff;
        m[3] = 16'h7fff;
        send_matrix(m, 0);
        m = diag(16'h0200);
        m[2] = 16'h7fff;
        m[6] = 16'h8000;
        send_matrix(m, 0);
        m = {16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001,
             16'h0000, 16'h0001, 16'h0000};
        send_matrix(m, 0);
        m = {16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
             16'h8000, 16'h7fff, 16'h7fff};
        send_matrix(m, 0);
        for (int k = 0; k < 7; k++) send_matrix(random_matrix(), 1);

        // Random part, with one drain and one stretch without sender gaps
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == 800) begin
                @(negedge i_clk);
                in_valid = 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            send_matrix(random_matrix(), !(n >= 300 && n < 500));
        end
        @(negedge i_clk);
        in_valid = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) $display("matrix3_inverse_determinant: match");
        else $display("matrix3_inverse_determinant: mismatch");
        $finish;
    end

endmodule
